@@ rtl/mtgp_pkg.sv @@
// Shared types, constants and the small remainder helper for the glyph placer.
// No dependencies; imported by every module of the block.
`default_nettype none

package mtgp_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int MAP_ENTRIES = 256;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int MAP_AW      = $clog2(MAP_ENTRIES);
   localparam int COLOR_W     = 5;
   localparam int ALPHA_W     = 3;
   localparam int CSR_IDX_W   = 3;

   // request kinds
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_TEXT  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERLAP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STYLES  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHAS  = 3'd4;

   // markup characters
   localparam logic [7:0] CH_CARET    = 8'h5E;
   localparam logic [7:0] CH_POP      = 8'h3C;
   localparam logic [7:0] CH_ALPHA_LO = 8'h23;
   localparam logic [7:0] CH_ALPHA_HI = 8'h27;
   localparam logic [7:0] CH_ZERO     = 8'h30;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [7:0]         char_code;
      logic [7:0]         glyph_slot;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]         glyph_index;
      logic [15:0]        source_x;
      logic [15:0]        source_y;
      logic [2:0]         alpha_layer;
      logic signed [15:0] dest_x;
      logic signed [15:0] dest_y;
      logic               stack_overflow;
   } rsp_payload_type;

   // topmost color and alpha from a stack level down to the bottom
   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [ALPHA_W-1:0] alpha;
   } attr_type;

   typedef struct packed {
      logic               push;
      logic               pop;
      logic               clear;
      logic               is_alpha;
      logic [COLOR_W-1:0] value;
   } stk_op_type;

   // restoring remainder over four numerator bits, starting from a partial
   // remainder below the modulus; a zero modulus acts as one
   function automatic logic [COLOR_W-1:0] rem_step(input logic [COLOR_W-1:0] part,
                                                   input logic [3:0]         bits,
                                                   input logic [COLOR_W-1:0] modulus);
      logic [COLOR_W-1:0] m;
      logic [COLOR_W:0]   r;
      m = (modulus == '0) ? COLOR_W'(1) : modulus;
      r = {1'b0, part};
      for (int i = 3; i >= 0; i--) begin
         r = {r[COLOR_W-1:0], bits[i]};
         if (r >= {1'b0, m}) begin
            r = r - {1'b0, m};
         end
      end
      return r[COLOR_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/mtgp_attr_cell.sv @@
// One level of the attribute stack: holds the running color/alpha summary.
// Depends on mtgp_pkg.
`default_nettype none

module mtgp_attr_cell (
   input  wire                clock,
   input  wire                push,
   input  wire                pop,
   input  mtgp_pkg::attr_type from_above,
   input  mtgp_pkg::attr_type from_below,
   output mtgp_pkg::attr_type level_q
);
   import mtgp_pkg::*;

   attr_type level_ff;
   attr_type level_in;

   always_comb begin
      level_in = level_ff;
      if (push) begin
         level_in = from_above;
      end else if (pop) begin
         level_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   assign level_q = level_ff;

endmodule

`default_nettype wire

@@ rtl/mtgp_attr_stack.sv @@
// Attribute stack as a row of shifting cells plus a fill count.
// Depends on mtgp_pkg and mtgp_attr_cell.
`default_nettype none

module mtgp_attr_stack (
   input  wire                  clock,
   input  wire                  reset,
   input  mtgp_pkg::stk_op_type op,
   output mtgp_pkg::attr_type   cur,
   output logic                 full
);
   import mtgp_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   attr_type         level_q [STACK_DEPTH];
   attr_type         new_top;
   logic             empty;
   logic             do_push;
   logic             do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff >= CNT_W'(STACK_DEPTH));
   assign cur     = empty ? attr_type'('0) : level_q[0];
   assign do_push = op.push && !full;
   assign do_pop  = op.pop && !empty;

   always_comb begin
      new_top = cur;
      if (op.is_alpha) begin
         new_top.alpha = op.value[ALPHA_W-1:0];
      end else begin
         new_top.color = op.value;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (op.clear) begin
         count_in = '0;
      end else if (do_push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      attr_type above;
      attr_type below;
      if (i == 0) begin : g_top
         assign above = new_top;
      end else begin : g_mid
         assign above = level_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bot
         assign below = level_q[i];
      end else begin : g_up
         assign below = level_q[i+1];
      end
      mtgp_attr_cell u_cell (
         .clock      (clock),
         .push       (do_push),
         .pop        (do_pop),
         .from_above (above),
         .from_below (below),
         .level_q    (level_q[i])
      );
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_full_push_drops: assert property (@(posedge clock) disable iff (reset)
      op.push && full && !op.clear |=> $stable(count_ff))
      else $error("push onto full stack changed count");

   a_empty_reads_zero: assert property (@(posedge clock) disable iff (reset)
      empty |-> cur == attr_type'('0))
      else $error("empty stack gives nonzero attributes");

endmodule

`default_nettype wire

@@ rtl/mtgp_glyph_map.sv @@
// Character-to-glyph map: 256x8 memory with registered read and per-entry
// valid bits cleared by reset. Depends on mtgp_pkg.
`default_nettype none

module mtgp_glyph_map (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        wr_en,
   input  wire [mtgp_pkg::MAP_AW-1:0] wr_addr,
   input  wire [7:0]                  wr_data,
   input  wire [mtgp_pkg::MAP_AW-1:0] rd_addr,
   output logic [7:0]                 rd_data
);
   import mtgp_pkg::*;

   logic [7:0]             mem [MAP_ENTRIES];
   logic [MAP_ENTRIES-1:0] vld_ff;
   logic [7:0]             rd_data_ff;
   logic                   rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   // never-written entries read as zero
   assign rd_data = rd_vld_ff ? rd_data_ff : 8'd0;

endmodule

`default_nettype wire

@@ rtl/markup_text_glyph_placer_top.sv @@
// Markup glyph placer: a drawn character gives one beat after its request
// beat (accept, map read, product stage, then the output register). Map
// loads, string starts and a lone caret finish in idle; an escape code also
// runs the two-step remainder, a drawn character the map read and product
// stage, stalling while the result side is full; only idle takes requests.
// Reset (synchronous): control registers to defaults, map reads as zero,
// stack empty, pen at 0; ready whenever the state is idle, which reset sets.
`default_nettype none

module markup_text_glyph_placer_top (
   input  wire                                   clock,
   input  wire                                   reset,
   // request channel
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  mtgp_pkg::req_payload_type             req_payload,
   // result channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output mtgp_pkg::rsp_payload_type             rsp_payload,
   // register write channel
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire [mtgp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire [7:0]                             csr_wdata
);
   import mtgp_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;  // ready for a request beat
   localparam logic [1:0] ST_ESC  = 2'd1;  // apply an escape code to the stack
   localparam logic [1:0] ST_MAP  = 2'd2;  // map data back, form the placement
   localparam logic [1:0] ST_OUT  = 2'd3;  // hand the placement to the output

   logic [1:0]  state_ff, state_in;
   logic        esc_ff, esc_in;       // caret seen, waiting for its code
   logic [7:0]  code_ff, code_in;     // escape code byte
   logic        half_ff, half_in;     // high nibble of the escape code reduced
   logic [COLOR_W-1:0] rem_ff, rem_in; // partial remainder after the high nibble
   logic [15:0] pen_x_ff, pen_x_in;
   logic [15:0] pen_y_ff, pen_y_in;
   logic        ovf_ff, ovf_in;       // sticky dropped-push flag

   // configuration
   logic [7:0]         width_ff, width_in;
   logic [7:0]         height_ff, height_in;
   logic [7:0]         overlap_ff, overlap_in;
   logic [COLOR_W-1:0] styles_ff, styles_in;
   logic [3:0]         alphas_ff, alphas_in;

   rsp_payload_type res_ff, res_in;          // placement waiting for output
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic req_fire;
   logic csr_fire;
   logic out_load;

   // escape decode
   logic       is_pop;
   logic       is_alpha;
   logic [7:0] alpha_num;
   logic [7:0] color_num;
   logic [7:0] esc_num;
   logic [COLOR_W-1:0] esc_mod;
   logic [COLOR_W-1:0] rem_part;
   logic [3:0]         rem_bits;
   logic [COLOR_W-1:0] esc_rem;

   stk_op_type stk_op;
   attr_type   cur_attr;
   logic       stk_full;
   logic [7:0] map_data;
   logic [15:0] src_x;
   logic [15:0] src_y;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;   // always ready
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // ---- glyph map: written on load beats, read at every request address ----
   mtgp_glyph_map u_map (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_fire && req_payload.req_type == REQ_LOAD),
      .wr_addr (req_payload.char_code),
      .wr_data (req_payload.glyph_slot),
      .rd_addr (req_payload.char_code),
      .rd_data (map_data)
   );

   // ---- escape code to stack operation ----
   // In ESC the remainder is formed high nibble first, then the low nibble
   // on top of the registered partial remainder; the push or pop lands on
   // the low-nibble step.
   assign is_pop    = (code_ff == CH_POP);
   assign is_alpha  = (code_ff >= CH_ALPHA_LO) && (code_ff <= CH_ALPHA_HI);
   assign alpha_num = code_ff - CH_ALPHA_LO;
   assign color_num = (code_ff >= CH_ZERO) ? (code_ff - CH_ZERO) : (CH_ZERO - code_ff);
   assign esc_num   = is_alpha ? alpha_num : color_num;
   assign esc_mod   = is_alpha ? {1'b0, alphas_ff} : styles_ff;
   assign rem_part  = half_ff ? rem_ff : '0;
   assign rem_bits  = half_ff ? esc_num[3:0] : esc_num[7:4];
   assign esc_rem   = rem_step(rem_part, rem_bits, esc_mod);

   always_comb begin
      stk_op.push     = (state_ff == ST_ESC) && half_ff && !is_pop;
      stk_op.pop      = (state_ff == ST_ESC) && half_ff && is_pop;
      stk_op.clear    = req_fire && (req_payload.req_type == REQ_START);
      stk_op.is_alpha = is_alpha;
      stk_op.value    = esc_rem;
   end

   mtgp_attr_stack u_stack (
      .clock (clock),
      .reset (reset),
      .op    (stk_op),
      .cur   (cur_attr),
      .full  (stk_full)
   );

   // products fit in 16 bits without wrapping
   assign src_x = {8'd0, map_data} * {8'd0, width_ff};
   assign src_y = 16'({11'd0, cur_attr.color} * {8'd0, height_ff});

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      esc_in   = esc_ff;
      code_in  = code_ff;
      half_in  = half_ff;
      rem_in   = rem_ff;
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      ovf_in   = ovf_ff;
      res_in   = res_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_payload.req_type)
                  REQ_START: begin
                     pen_x_in = req_payload.start_x;
                     pen_y_in = req_payload.start_y;
                     esc_in   = 1'b0;
                     ovf_in   = 1'b0;
                  end
                  REQ_TEXT: begin
                     if (esc_ff) begin
                        esc_in = 1'b0;
                        if (req_payload.char_code != CH_CARET) begin
                           code_in  = req_payload.char_code;
                           state_in = ST_ESC;
                        end else begin
                           state_in = ST_MAP;   // caret caret draws a caret
                        end
                     end else if (req_payload.char_code == CH_CARET) begin
                        esc_in = 1'b1;
                     end else begin
                        state_in = ST_MAP;
                     end
                  end
                  default: begin
                     // map loads go straight to the memory; code 3 is ignored
                  end
               endcase
            end
         end
         ST_ESC: begin
            if (!half_ff) begin
               half_in = 1'b1;
               rem_in  = esc_rem;
            end else begin
               half_in = 1'b0;
               if (!is_pop && stk_full) begin
                  ovf_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_MAP: begin
            res_in.glyph_index    = map_data;
            res_in.source_x       = src_x;
            res_in.source_y       = src_y;
            res_in.alpha_layer    = cur_attr.alpha;
            res_in.dest_x         = pen_x_ff;
            res_in.dest_y         = pen_y_ff;
            res_in.stack_overflow = ovf_ff;
            pen_x_in = pen_x_ff + {8'd0, width_ff} - {8'd0, overlap_ff};
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---- output register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   // ---- register writes ----
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      overlap_in = overlap_ff;
      styles_in  = styles_ff;
      alphas_in  = alphas_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_WIDTH:   width_in   = csr_wdata;
            CSR_HEIGHT:  height_in  = csr_wdata;
            CSR_OVERLAP: overlap_in = csr_wdata;
            CSR_STYLES:  styles_in  = csr_wdata[COLOR_W-1:0];
            CSR_ALPHAS:  alphas_in  = csr_wdata[3:0];
            default: begin
               // writes past the register list are dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         esc_ff       <= 1'b0;
         half_ff      <= 1'b0;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= 8'd9;
         height_ff    <= 8'd16;
         overlap_ff   <= 8'd0;
         styles_ff    <= COLOR_W'(1);
         alphas_ff    <= 4'd2;
      end else begin
         state_ff     <= state_in;
         esc_ff       <= esc_in;
         half_ff      <= half_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         overlap_ff   <= overlap_in;
         styles_ff    <= styles_in;
         alphas_ff    <= alphas_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_esc_clears_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ESC |-> !esc_ff)
      else $error("escape applied while a caret is still pending");

   a_esc_two_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ESC && !half_ff |=> state_ff == ST_ESC && half_ff)
      else $error("escape remainder skipped its second step");

   a_map_then_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAP |=> state_ff == ST_OUT)
      else $error("placement not staged after map read");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_payload.req_type == REQ_LOAD |=> state_ff == ST_IDLE)
      else $error("map load left the idle state");

   a_out_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("staged placement not delivered to output register");

endmodule

`default_nettype wire
